FILE: design/lc3_pkg.sv
package lc3_pkg;

    localparam int ADDR_BITS = 16;
    localparam int MEM_WORDS = 1 << ADDR_BITS;
    localparam logic [15:0] FILL_WORD = 16'h7777;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_EXEC  = 2'd2;

    localparam logic [1:0] CC_NEG  = 2'd0;
    localparam logic [1:0] CC_ZERO = 2'd1;
    localparam logic [1:0] CC_POS  = 2'd2;

    localparam logic [3:0] OP_BR   = 4'h0;
    localparam logic [3:0] OP_ADD  = 4'h1;
    localparam logic [3:0] OP_LD   = 4'h2;
    localparam logic [3:0] OP_ST   = 4'h3;
    localparam logic [3:0] OP_JSR  = 4'h4;
    localparam logic [3:0] OP_AND  = 4'h5;
    localparam logic [3:0] OP_LDR  = 4'h6;
    localparam logic [3:0] OP_STR  = 4'h7;
    localparam logic [3:0] OP_NOT  = 4'h9;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_STI  = 4'hB;
    localparam logic [3:0] OP_JMP  = 4'hC;
    localparam logic [3:0] OP_LEA  = 4'hE;
    localparam logic [3:0] OP_TRAP = 4'hF;

    typedef logic [ADDR_BITS-1:0] t_addr;

    typedef struct packed {
        logic        we;
        logic        re;
        t_addr       addr;
        logic [15:0] wdata;
    } t_mem_req;

    function automatic logic [1:0] cc_of(input logic [15:0] v);
        if (v[15]) begin
            return CC_NEG;
        end else if (v == 16'd0) begin
            return CC_ZERO;
        end
        return CC_POS;
    endfunction

endpackage

FILE: design/lc3_mem.sv
module lc3_mem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lc3_pkg::t_mem_req i_req,
    output logic [15:0]       o_rdata,
    output logic              o_clearing
);
    import lc3_pkg::*;

    logic [15:0] r_mem [MEM_WORDS];
    logic [ADDR_BITS:0] r_clr;
    logic [ADDR_BITS:0] n_clr;

    assign o_clearing = !r_clr[ADDR_BITS];

    always_comb begin
        n_clr = r_clr;
        if (o_clearing) begin
            n_clr = r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else begin
            r_clr <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_clearing) begin
            r_mem[r_clr[ADDR_BITS-1:0]] <= FILL_WORD;
        end else if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            o_rdata <= r_mem[i_req.addr];
        end
    end
endmodule

FILE: design/lc3_instruction_executor.sv
// channel  | valid    | stall    | payload
// request  | i_valid  | o_stall  | i_req_type, i_addr, i_data
// result   | o_valid  | i_stall  | o_pc, o_cond, o_halted, o_reg_index, o_reg_value, o_last
//
// States from accept to next accept with the output free: load, start, execute while halted
// and an unknown request OUT; BR/ALU/JMP/JSR/LEA/RTI FETCH, DEC, OUT; LD/LDR FETCH, DEC,
// WB, OUT; ST/STR FETCH, DEC, MEM, OUT; LDI/STI FETCH, DEC, IND, WB or MEM, OUT; set by the
// single-port main memory (fetch, address, data). TRAP: FETCH, DEC, DUMP (eight results,
// one per cycle while the output is not stalled). After reset the memory is filled with
// 0x7777 before any request is taken. The result register holds while i_stall is high.
module lc3_instruction_executor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_addr,
    input  logic [15:0] i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_pc,
    output logic [1:0]  o_cond,
    output logic        o_halted,
    output logic [2:0]  o_reg_index,
    output logic [15:0] o_reg_value,
    output logic        o_last
);
    import lc3_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_IND   = 3'd3;
    localparam logic [2:0] S_MEM   = 3'd4;
    localparam logic [2:0] S_WB    = 3'd5;
    localparam logic [2:0] S_DUMP  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]  r_state, n_state;
    logic [15:0] r_pc, n_pc;
    logic [1:0]  r_cc, n_cc;
    logic        r_halt, n_halt;
    logic [15:0] r_rf [8];
    logic        r_rf_we;
    logic [2:0]  r_rf_wa;
    logic [15:0] r_rf_wd;
    logic        n_rf_we;
    logic [2:0]  n_rf_wa;
    logic [15:0] n_rf_wd;
    logic [15:0] r_ir, n_ir;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_ovalid;
    logic [2:0]  r_oidx;
    logic [15:0] r_oval;
    logic        r_olast;
    logic [15:0] r_opc;
    logic [1:0]  r_ocond;
    logic        r_ohalt;
    logic        out_free;
    logic        accept;
    t_mem_req    mreq;
    logic [15:0] rdata;
    logic        clearing;
    logic [3:0]  op;
    logic [15:0] off9, off6, off11, imm5, sr1v, drv, srb, bv, v;
    logic        emit;
    logic [2:0]  e_idx;
    logic [15:0] e_val;
    logic        e_last;

    lc3_mem u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (mreq),
        .o_rdata    (rdata),
        .o_clearing (clearing)
    );

    assign out_free = !r_ovalid || !i_stall;
    assign o_stall  = (r_state != S_IDLE) || clearing || !out_free;
    assign accept   = i_valid && !o_stall;

    assign op    = r_ir[15:12];
    assign off9  = {{7{r_ir[8]}}, r_ir[8:0]};
    assign off6  = {{10{r_ir[5]}}, r_ir[5:0]};
    assign off11 = {{5{r_ir[10]}}, r_ir[10:0]};
    assign imm5  = {{11{r_ir[4]}}, r_ir[4:0]};
    assign sr1v  = r_rf[r_ir[8:6]];
    assign drv   = r_rf[r_ir[11:9]];
    assign srb   = r_rf[r_ir[2:0]];
    assign bv    = r_ir[5] ? imm5 : srb;

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_cc    = r_cc;
        n_halt  = r_halt;
        n_ir    = r_ir;
        n_cnt   = r_cnt;
        n_rf_we = 1'b0;
        n_rf_wa = r_ir[11:9];
        n_rf_wd = 16'd0;
        mreq    = '0;
        emit    = 1'b0;
        e_idx   = 3'd0;
        e_val   = 16'd0;
        e_last  = 1'b1;
        v       = 16'd0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_req_type)
                        REQ_LOAD: begin
                            mreq.we    = 1'b1;
                            mreq.addr  = i_addr[ADDR_BITS-1:0];
                            mreq.wdata = i_data;
                            n_state    = S_OUT;
                        end
                        REQ_START: begin
                            n_pc    = i_addr;
                            n_halt  = 1'b0;
                            n_state = S_OUT;
                        end
                        REQ_EXEC: begin
                            if (r_halt) begin
                                n_state = S_OUT;
                            end else begin
                                mreq.re   = 1'b1;
                                mreq.addr = r_pc[ADDR_BITS-1:0];
                                n_state   = S_FETCH;
                            end
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_FETCH: begin
                n_ir    = rdata;
                n_pc    = r_pc + 16'd1;
                n_state = S_DEC;
            end
            S_DEC: begin
                n_state = S_OUT;
                unique case (op) inside
                    OP_BR: begin
                        if ((r_ir[11] && r_cc == CC_NEG) || (r_ir[10] && r_cc == CC_ZERO)
                                || (r_ir[9] && r_cc == CC_POS)) begin
                            n_pc = r_pc + off9;
                        end
                    end
                    OP_ADD, OP_AND, OP_NOT: begin
                        if (op == OP_ADD) begin
                            v = sr1v + bv;
                        end else if (op == OP_AND) begin
                            v = sr1v & bv;
                        end else begin
                            v = ~sr1v;
                        end
                        n_rf_we = 1'b1;
                        n_rf_wd = v;
                        n_cc    = cc_of(v);
                    end
                    OP_LD, OP_LDI, OP_STI, OP_LDR: begin
                        v         = (op == OP_LDR) ? sr1v + off6 : r_pc + off9;
                        mreq.re   = 1'b1;
                        mreq.addr = v[ADDR_BITS-1:0];
                        n_state   = (op == OP_LD || op == OP_LDR) ? S_WB : S_IND;
                    end
                    OP_ST, OP_STR: begin
                        v          = (op == OP_STR) ? sr1v + off6 : r_pc + off9;
                        mreq.we    = 1'b1;
                        mreq.addr  = v[ADDR_BITS-1:0];
                        mreq.wdata = drv;
                        n_state    = S_MEM;
                    end
                    OP_JSR: begin
                        n_pc    = r_ir[11] ? r_pc + off11 : sr1v;
                        n_rf_we = 1'b1;
                        n_rf_wa = 3'd7;
                        n_rf_wd = r_pc;
                    end
                    OP_JMP: n_pc = sr1v;
                    OP_LEA: begin
                        n_rf_we = 1'b1;
                        n_rf_wd = r_pc + off9;
                    end
                    OP_TRAP: begin
                        n_halt  = 1'b1;
                        n_cnt   = 3'd0;
                        n_state = S_DUMP;
                    end
                    default: ;
                endcase
            end
            S_IND: begin
                if (op == OP_STI) begin
                    mreq.we    = 1'b1;
                    mreq.addr  = rdata[ADDR_BITS-1:0];
                    mreq.wdata = drv;
                    n_state    = S_MEM;
                end else begin
                    mreq.re   = 1'b1;
                    mreq.addr = rdata[ADDR_BITS-1:0];
                    n_state   = S_WB;
                end
            end
            S_WB: begin
                n_rf_we = 1'b1;
                n_rf_wd = rdata;
                n_cc    = cc_of(rdata);
                n_state = S_OUT;
            end
            S_MEM: n_state = S_OUT;
            S_DUMP: begin
                if (out_free) begin
                    emit   = 1'b1;
                    e_idx  = r_cnt;
                    e_val  = r_rf[r_cnt];
                    e_last = (r_cnt == 3'd7);
                    n_cnt  = r_cnt + 3'd1;
                    if (r_cnt == 3'd7) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_OUT: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pc     <= 16'd0;
            r_cc     <= CC_ZERO;
            r_halt   <= 1'b0;
            r_cnt    <= 3'd0;
            r_ovalid <= 1'b0;
            r_rf_we  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_cc    <= n_cc;
            r_halt  <= n_halt;
            r_cnt   <= n_cnt;
            r_rf_we <= n_rf_we;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ir    <= n_ir;
        r_rf_wa <= n_rf_wa;
        r_rf_wd <= n_rf_wd;
        if (emit) begin
            r_opc   <= n_pc;
            r_ocond <= n_cc;
            r_ohalt <= n_halt;
            r_oidx  <= e_idx;
            r_oval  <= e_val;
            r_olast <= e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 8; k++) begin
                r_rf[k] <= FILL_WORD;
            end
        end else if (r_rf_we) begin
            r_rf[r_rf_wa] <= r_rf_wd;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_pc        = r_opc;
    assign o_cond      = r_ocond;
    assign o_halted    = r_ohalt;
    assign o_reg_index = r_oidx;
    assign o_reg_value = r_oval;
    assign o_last      = r_olast;
endmodule

FILE: design/lc3_checker.sv
module lc3_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_cond,
    input logic [2:0]  o_reg_index,
    input logic        o_halted,
    input logic        o_last
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid) else $error("result dropped under stall");
    a_cond: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_cond != 2'd3) else $error("bad condition code");
    a_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_halted) else $error("partial result while running");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_reg_index != 3'd0 && o_reg_index != 3'd7 |-> !o_last)
        else $error("last on a middle dump entry");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall) else $error("second transaction taken too early");
endmodule

bind lc3_instruction_executor lc3_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_cond(o_cond), .o_reg_index(o_reg_index),
    .o_halted(o_halted), .o_last(o_last)
);
